// ----- sv/lkvc_pkg.sv -----
// Shared types and constants of the LRU key-value cache.
// Depends on nothing; every other file of the block imports it.
package lkvc_pkg;

   localparam int ENTRIES    = 16;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W      = $clog2(ENTRIES + 1);
   localparam int KEY_W      = 32;
   localparam int DATA_W     = 32;
   localparam int LIMIT_W    = 5;
   localparam int CMP_W      = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-3:0] REG_ENTRY_LIMIT = '0;
   localparam logic [LIMIT_W-1:0]    LIMIT_RESET     = LIMIT_W'(16);
   localparam logic [DATA_W-1:0]     MISS_DATA       = '1;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } opcode_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_get;
   } dp_status_type;

endpackage

// ----- sv/lkvc_if.sv -----
// Valid/ready channel interfaces for request and response items.
// Depends on lkvc_pkg.
interface lkvc_req_if import lkvc_pkg::*;;
   logic                     valid;
   logic                     ready;
   opcode_type               opcode;
   logic signed [KEY_W-1:0]  lookup_key;
   logic signed [DATA_W-1:0] data_word;

   modport source (output valid, opcode, lookup_key, data_word, input ready);
   modport sink   (input valid, opcode, lookup_key, data_word, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] read_data;
   logic                     found;

   modport source (output valid, read_data, found, input ready);
   modport sink   (input valid, read_data, found, output ready);
endinterface

// ----- sv/lru_key_value_cache.sv -----
// Channel   Dir  Handshake          Payload
// req_if    in   valid/ready        opcode, lookup_key, data_word
// rsp_if    out  valid/ready        read_data, found (one item per get)
// csr (APB) in   psel/penable/pready paddr, pwdata, prdata (entry_limit at 0x0)
//
// Each item passes IDLE, which registers the request and the parallel key
// match, then UPDATE, which updates the table, ranks and response register.
// A new item is accepted while an earlier response still waits to be taken.
// A get stalls in its update cycle while the response register is occupied.
// Synchronous reset clears valid marks, ranks and occupancy at once; no sweep.
// Top level of the LRU key-value cache. Depends on lkvc_pkg, lkvc_if,
// lkvc_csr, lkvc_ctrl and lkvc_dp.
module lru_key_value_cache import lkvc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lkvc_req_if.sink              req_if,
   lkvc_rsp_if.source            rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [LIMIT_W-1:0] entry_limit;
   dp_cmd_type         cmd;
   dp_status_type      status;

   lkvc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .entry_limit (entry_limit)
   );

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lkvc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .entry_limit    (entry_limit),
      .req_opcode     (req_if.opcode),
      .req_lookup_key (req_if.lookup_key),
      .req_data_word  (req_if.data_word),
      .rsp_read_data  (rsp_if.read_data),
      .rsp_found      (rsp_if.found)
   );

endmodule

// ----- sv/lkvc_csr.sv -----
// APB-style configuration register file: holds entry_limit.
// Depends on lkvc_pkg.
module lkvc_csr import lkvc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [LIMIT_W-1:0]    entry_limit
);

   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] limit_in;
   logic               sel_limit;

   assign pready    = 1'b1;
   assign sel_limit = (paddr[CSR_ADDR_W-1:2] == REG_ENTRY_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && pready && sel_limit) begin
         limit_in = pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata      = sel_limit ? CSR_DATA_W'(limit_ff) : '0;
   assign entry_limit = limit_ff;

endmodule

// ----- sv/lkvc_ctrl.sv -----
// Controller: sequences capture and commit of one item, owns response valid.
// Depends on lkvc_pkg.
module lkvc_ctrl import lkvc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.capture = req_valid && (state_ff == ST_IDLE);
   // a get waits in UPDATE until the response register is free
   assign cmd.commit  = (state_ff == ST_UPDATE) &&
                        (!status.is_get || !rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (cmd.commit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (cmd.commit && status.is_get) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- sv/lkvc_dp.sv -----
// Datapath: key/value table, parallel key match, recency ranks, response register.
// Depends on lkvc_pkg.
module lkvc_dp import lkvc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  logic [LIMIT_W-1:0]       entry_limit,
   input  opcode_type               req_opcode,
   input  logic signed [KEY_W-1:0]  req_lookup_key,
   input  logic signed [DATA_W-1:0] req_data_word,
   output logic signed [DATA_W-1:0] rsp_read_data,
   output logic                     rsp_found
);

   logic [KEY_W-1:0]   key_ff   [ENTRIES];
   logic [DATA_W-1:0]  value_ff [ENTRIES];
   logic [IDX_W-1:0]   rank_ff  [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [OCC_W-1:0]   occ_ff;

   logic [ENTRIES-1:0] match_ff;
   opcode_type         op_ff;
   logic [KEY_W-1:0]   req_key_ff;
   logic [DATA_W-1:0]  req_data_ff;
   logic [DATA_W-1:0]  read_data_ff;
   logic               found_ff;

   logic [ENTRIES-1:0] match_in;
   logic [ENTRIES-1:0] victim_vec;
   logic [ENTRIES-1:0] free_vec;
   logic [ENTRIES-1:0] target_vec;
   logic [IDX_W-1:0]   slot_idx;
   logic [IDX_W-1:0]   oldest_rank;
   logic [CMP_W-1:0]   eff_limit;
   logic [OCC_W-1:0]   bound;
   logic               hit;
   logic               full;
   logic               is_put;
   logic               write_en;
   logic               promote_en;
   logic               insert;

   // compare the incoming key against every valid entry
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (key_ff[i] == KEY_W'(req_lookup_key));
      end
   end

   always_comb begin
      if (entry_limit == '0) begin
         eff_limit = CMP_W'(1);
      end else if (CMP_W'(entry_limit) > CMP_W'(ENTRIES)) begin
         eff_limit = CMP_W'(ENTRIES);
      end else begin
         eff_limit = CMP_W'(entry_limit);
      end
   end

   assign hit         = |match_ff;
   assign is_put      = (op_ff == OP_PUT);
   assign full        = CMP_W'(occ_ff) >= eff_limit;
   assign oldest_rank = IDX_W'(occ_ff - OCC_W'(1));
   // lowest free slot
   assign free_vec    = ~valid_ff & (valid_ff + ENTRIES'(1));

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == oldest_rank);
      end
   end

   assign target_vec = hit ? match_ff : (full ? victim_vec : free_vec);

   always_comb begin
      slot_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (target_vec[i]) begin
            slot_idx = slot_idx | IDX_W'(i);
         end
      end
   end

   // entries more recent than the bound age by one
   assign bound      = (hit || full) ? OCC_W'(rank_ff[slot_idx]) : occ_ff;
   assign write_en   = cmd.commit && is_put;
   assign promote_en = cmd.commit && (hit || is_put);
   assign insert     = write_en && !hit && !full;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         match_ff    <= match_in;
         op_ff       <= req_opcode;
         req_key_ff  <= KEY_W'(req_lookup_key);
         req_data_ff <= DATA_W'(req_data_word);
      end
      if (write_en) begin
         value_ff[slot_idx] <= req_data_ff;
         if (!hit) begin
            key_ff[slot_idx] <= req_key_ff;
         end
      end
      if (cmd.commit && !is_put) begin
         read_data_ff <= hit ? value_ff[slot_idx] : MISS_DATA;
         found_ff     <= hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (insert) begin
            valid_ff <= valid_ff | free_vec;
            occ_ff   <= occ_ff + OCC_W'(1);
         end
         if (promote_en) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (target_vec[i]) begin
                  rank_ff[i] <= '0;
               end else if (valid_ff[i] && (OCC_W'(rank_ff[i]) < bound)) begin
                  rank_ff[i] <= rank_ff[i] + IDX_W'(1);
               end
            end
         end
      end
   end

   assign status.is_get = !is_put;
   assign rsp_read_data = read_data_ff;
   assign rsp_found     = found_ff;

endmodule

// ----- sv/lkvc_checker.sv -----
// Port-level checker for lru_key_value_cache, attached by bind.
// Depends on lkvc_pkg.
module lkvc_checker import lkvc_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input opcode_type               req_opcode,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_read_data,
   input logic                     rsp_found
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_found))
      else $error("response changed while stalled");

   a_miss_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_read_data == DATA_W'(MISS_DATA))
      else $error("miss response without all-ones data");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted during update");

   a_rsp_from_get: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_opcode == OP_GET), 2))
      else $error("response not caused by a get two cycles back");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_opcode    (req_if.opcode),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_read_data (rsp_if.read_data),
   .rsp_found     (rsp_if.found)
);
